// ----- hw/rtl/lkvc_pkg.sv -----
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

   localparam int KEY_W  = 32;
   localparam int DATA_W = 32;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_STORE  = 1'b1;

   localparam logic [DATA_W-1:0] MISS_DATA  = '1;
   localparam logic [DATA_W-1:0] STORE_DATA = '0;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef struct packed {
      logic rd_en;
      logic key_we;
      logic val_we;
      logic rank_we;
   } mem_ctrl_type;

endpackage

// ----- hw/rtl/lkvc_entry_store.sv -----
// Entry memories of the LRU key/value cache: key, value and recency rank.
module lkvc_entry_store
   import lkvc_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic            clock,
   input  mem_ctrl_type    ctrl,
   input  logic [IW-1:0]   rd_addr,
   input  logic [IW-1:0]   wr_addr,
   input  key_type         key_wd,
   input  data_type        val_wd,
   input  logic [IW-1:0]   rank_wd,
   output key_type         key_rd,
   output data_type        val_rd,
   output logic [IW-1:0]   rank_rd
);

   key_type       key_mem  [DEPTH];
   data_type      val_mem  [DEPTH];
   logic [IW-1:0] rank_mem [DEPTH];

   key_type       key_rd_ff;
   data_type      val_rd_ff;
   logic [IW-1:0] rank_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.key_we) begin
         key_mem[wr_addr] <= key_wd;
      end
      if (ctrl.val_we) begin
         val_mem[wr_addr] <= val_wd;
      end
      if (ctrl.rank_we) begin
         rank_mem[wr_addr] <= rank_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         key_rd_ff  <= key_mem[rd_addr];
         val_rd_ff  <= val_mem[rd_addr];
         rank_rd_ff <= rank_mem[rd_addr];
      end
   end

   assign key_rd  = key_rd_ff;
   assign val_rd  = val_rd_ff;
   assign rank_rd = rank_rd_ff;

endmodule

// ----- hw/rtl/lru_key_value_cache_top.sv -----
// Top level of the fully associative LRU key/value cache.
// A word is taken when start is high and busy is low, and busy stays high until its result
// is out. The entry memories have one read port: one pass walks every slot to find the
// key, the least recent entry and the first free slot, and a second pass walks them again to
// age the recency ranks, one slot per cycle. A lookup miss, or a store that finds no victim
// and no free slot, ends after the first pass; every other word takes both. The result is
// shown for exactly one cycle on rsp_valid and cannot be held off; csr_wdata sets how many
// entries are held before the least recent one is evicted (0 acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES).
module lru_key_value_cache_top
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic signed [KEY_W-1:0]  req_key,
   input  logic signed [DATA_W-1:0] req_data_in,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic signed [DATA_W-1:0] rsp_data_out,
   input  logic                     csr_we,
   input  logic [CFG_W-1:0]         csr_wdata
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(MAX_ENTRIES);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CFG_W-1:0]       eiu_ff, eiu_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          slot_ff, slot_in;

   logic     cmd_ff, cmd_in;
   key_type  key_ff, key_in;
   data_type data_ff, data_in;

   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_slot_ff, hit_slot_in;
   logic [IW-1:0] hit_rank_ff, hit_rank_in;
   data_type      hit_val_ff, hit_val_in;
   logic          any_ff, any_in;
   logic [IW-1:0] vic_slot_ff, vic_slot_in;
   logic [IW-1:0] best_ff, best_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_slot_ff, free_slot_in;

   logic [IW-1:0] tgt_ff, tgt_in;
   logic [IW-1:0] thr_ff, thr_in;
   logic          inc_all_ff, inc_all_in;
   logic          wr_key_ff, wr_key_in;
   logic          wr_val_ff, wr_val_in;
   logic          ins_ff, ins_in;

   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_found_ff, rsp_found_in;
   data_type rsp_data_ff, rsp_data_in;

   mem_ctrl_type  ctrl;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rank_wd;
   key_type       key_rd;
   data_type      val_rd;
   logic [IW-1:0] rank_rd;

   logic issuing;
   logic walk_done;
   logic cur_valid;
   logic cache_full;

   lkvc_entry_store #(
      .DEPTH (MAX_ENTRIES),
      .IW    (IW)
   ) u_store (
      .clock   (clock),
      .ctrl    (ctrl),
      .rd_addr (iss_ff[IW-1:0]),
      .wr_addr (wr_addr),
      .key_wd  (key_ff),
      .val_wd  (data_ff),
      .rank_wd (rank_wd),
      .key_rd  (key_rd),
      .val_rd  (val_rd),
      .rank_rd (rank_rd)
   );

   assign issuing   = (iss_ff != LAST_CNT);
   assign walk_done = !issuing && !pend_ff;
   assign cur_valid = valid_ff[slot_ff];
   assign cache_full = (eiu_ff == '0) ? (occ_ff != '0) :
                       ((32'(occ_ff) >= 32'(eiu_ff)) || (32'(occ_ff) >= 32'(MAX_ENTRIES)));

   always_comb begin
      state_in     = state_ff;
      eiu_in       = csr_we ? csr_wdata : eiu_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      slot_in      = slot_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      any_in       = any_ff;
      vic_slot_in  = vic_slot_ff;
      best_in      = best_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      tgt_in       = tgt_ff;
      thr_in       = thr_ff;
      inc_all_in   = inc_all_ff;
      wr_key_in    = wr_key_ff;
      wr_val_in    = wr_val_ff;
      ins_in       = ins_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;
      wr_addr      = slot_ff;
      rank_wd      = rank_rd + IW'(1);

      case (state_ff)
         ST_IDLE: begin
            iss_in = '0;
            if (start) begin
               cmd_in   = req_cmd;
               key_in   = req_key;
               data_in  = req_data_in;
               hit_in   = 1'b0;
               any_in   = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, examine the previous slot
            if (issuing) begin
               ctrl.rd_en = 1'b1;
               iss_in     = iss_ff + CW'(1);
               slot_in    = iss_ff[IW-1:0];
               pend_in    = 1'b1;
            end
            if (pend_ff) begin
               if (cur_valid && (key_rd == key_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = slot_ff;
                  hit_rank_in = rank_rd;
                  hit_val_in  = val_rd;
               end
               if (cur_valid && (!any_ff || (rank_rd > best_ff))) begin
                  any_in      = 1'b1;
                  vic_slot_in = slot_ff;
                  best_in     = rank_rd;
               end
               if (!cur_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = slot_ff;
               end
            end
            if (walk_done) begin
               iss_in   = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            inc_all_in = 1'b0;
            wr_key_in  = 1'b0;
            wr_val_in  = 1'b0;
            ins_in     = 1'b0;
            state_in   = ST_UPDATE;
            if (hit_ff) begin
               tgt_in       = hit_slot_ff;
               thr_in       = hit_rank_ff;
               wr_val_in    = (cmd_ff == CMD_STORE);
               rsp_found_in = 1'b1;
               rsp_data_in  = (cmd_ff == CMD_STORE) ? STORE_DATA : hit_val_ff;
            end else if (cmd_ff == CMD_LOOKUP) begin
               rsp_found_in = 1'b0;
               rsp_data_in  = MISS_DATA;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cache_full && any_ff) begin
               tgt_in       = vic_slot_ff;
               thr_in       = best_ff;
               wr_key_in    = 1'b1;
               wr_val_in    = 1'b1;
               rsp_found_in = 1'b0;
               rsp_data_in  = STORE_DATA;
            end else if (free_ff) begin
               tgt_in       = free_slot_ff;
               inc_all_in   = 1'b1;
               wr_key_in    = 1'b1;
               wr_val_in    = 1'b1;
               ins_in       = 1'b1;
               rsp_found_in = 1'b0;
               rsp_data_in  = STORE_DATA;
            end else begin
               rsp_found_in = 1'b0;
               rsp_data_in  = STORE_DATA;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_UPDATE: begin
            // age every valid entry more recent than the target, or every valid entry on an insert
            if (issuing) begin
               ctrl.rd_en = 1'b1;
               iss_in     = iss_ff + CW'(1);
               slot_in    = iss_ff[IW-1:0];
               pend_in    = 1'b1;
            end
            if (pend_ff && cur_valid && (slot_ff != tgt_ff) &&
                (inc_all_ff || (rank_rd < thr_ff))) begin
               ctrl.rank_we = 1'b1;
            end
            if (walk_done) begin
               iss_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            wr_addr      = tgt_ff;
            rank_wd      = '0;
            ctrl.rank_we = 1'b1;
            ctrl.key_we  = wr_key_ff;
            ctrl.val_we  = wr_val_ff;
            if (ins_ff) begin
               valid_in[tgt_ff] = 1'b1;
               occ_in           = occ_ff + CW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eiu_ff       <= CFG_RESET;
         valid_ff     <= '0;
         occ_ff       <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         any_ff       <= 1'b0;
         free_ff      <= 1'b0;
         inc_all_ff   <= 1'b0;
         wr_key_ff    <= 1'b0;
         wr_val_ff    <= 1'b0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eiu_ff       <= eiu_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         any_ff       <= any_in;
         free_ff      <= free_in;
         inc_all_ff   <= inc_all_in;
         wr_key_ff    <= wr_key_in;
         wr_val_ff    <= wr_val_in;
         ins_ff       <= ins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      data_ff      <= data_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      vic_slot_ff  <= vic_slot_in;
      best_ff      <= best_in;
      free_slot_ff <= free_slot_in;
      tgt_ff       <= tgt_in;
      thr_ff       <= thr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_data_out = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_rsp_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> rsp_valid)
      else $error("finished word produced no result");

   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result given while a word is still being worked");

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(MAX_ENTRIES))
      else $error("occupancy above the number of entries");

   a_target_not_aged: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_UPDATE) && ctrl.rank_we) |-> (wr_addr != tgt_ff))
      else $error("target entry aged during rank update");

   a_insert_free_slot: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && ins_ff) |-> !valid_ff[tgt_ff])
      else $error("insert into an occupied slot");
`endif

endmodule

// ----- dv/tb_lru_key_value_cache_top.sv -----
// Self-checking testbench for the LRU key/value cache: directed and random words, live predictor.
module tb_lru_key_value_cache_top;
   import lkvc_pkg::*;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 2 * SLOTS + 12;

   typedef struct {
      bit               is_cfg;
      logic [CFG_W-1:0] limit;
      logic             cmd;
      key_type          key;
      data_type         data;
   } cache_word_type;

   typedef struct {
      logic     found;
      data_type data;
   } cache_rsp_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_cmd = CMD_LOOKUP;
   logic signed [KEY_W-1:0]  req_key = '0;
   logic signed [DATA_W-1:0] req_data_in = '0;
   logic                     rsp_valid;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic                     csr_we = 1'b0;
   logic [CFG_W-1:0]         csr_wdata = '0;

   cache_word_type word_queue[$];
   cache_rsp_type  pending_rsp[$];

   // predictor state
   key_type          slot_key[SLOTS];
   data_type         slot_val[SLOTS];
   bit               slot_live[SLOTS];
   int unsigned      slot_age[SLOTS];
   int unsigned      slot_fill;
   logic [CFG_W-1:0] slot_limit;

   bit word_taken = 1'b0;
   int gap_left   = 0;
   int cycle_cnt  = 0;
   int errors     = 0;
   int n_lookup   = 0;
   int n_store    = 0;
   int n_hit      = 0;
   int n_evict    = 0;
   int n_limit    = 0;
   int n_rsp      = 0;

   lru_key_value_cache_top #(
      .MAX_ENTRIES(SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_data_in (req_data_in),
      .rsp_valid   (rsp_valid),
      .rsp_found   (rsp_found),
      .rsp_data_out(rsp_data_out),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void make_recent(input int s, input int unsigned old_age);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] && i != s && slot_age[i] < old_age) slot_age[i] = slot_age[i] + 1;
      end
      slot_age[s] = 0;
   endfunction

   function automatic void cache_access(input logic cmd, input key_type k, input data_type v,
                                        output logic hit, output data_type dout);
      int          at;
      int          victim;
      int unsigned best;
      int unsigned cap;
      bit          any;
      at     = -1;
      victim = 0;
      best   = 0;
      any    = 1'b0;
      cap    = slot_limit;
      if (cap == 0) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_live[i] && slot_key[i] == k) at = i;
      end
      hit  = (at >= 0);
      dout = STORE_DATA;
      if (cmd == CMD_LOOKUP) begin
         if (at >= 0) begin
            dout = slot_val[at];
            make_recent(at, slot_age[at]);
         end else begin
            dout = MISS_DATA;
         end
      end else if (at >= 0) begin
         slot_val[at] = v;
         make_recent(at, slot_age[at]);
      end else begin
         if (slot_fill >= cap) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_live[i] && (!any || slot_age[i] > best)) begin
                  victim = i;
                  best   = slot_age[i];
                  any    = 1'b1;
               end
            end
         end
         if (any) begin
            slot_key[victim] = k;
            slot_val[victim] = v;
            make_recent(victim, best);
            n_evict++;
         end else begin
            at = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!slot_live[i]) at = i;
            end
            if (at >= 0) begin
               for (int j = 0; j < SLOTS; j++) begin
                  if (slot_live[j]) slot_age[j] = slot_age[j] + 1;
               end
               slot_live[at] = 1'b1;
               slot_key[at]  = k;
               slot_val[at]  = v;
               slot_age[at]  = 0;
               slot_fill     = slot_fill + 1;
            end
         end
      end
   endfunction

   task automatic add_access(input logic cmd, input key_type k, input data_type v);
      cache_word_type w;
      w.is_cfg = 1'b0;
      w.limit  = '0;
      w.cmd    = cmd;
      w.key    = k;
      w.data   = v;
      word_queue.push_back(w);
   endtask

   task automatic add_limit(input logic [CFG_W-1:0] value);
      cache_word_type w;
      w.is_cfg = 1'b1;
      w.limit  = value;
      w.cmd    = CMD_LOOKUP;
      w.key    = '0;
      w.data   = '0;
      word_queue.push_back(w);
   endtask

   // driver: present words and register writes at the falling edge
   always @(negedge clock) begin
      logic           go;
      logic           cfg_go;
      cache_word_type head;
      go     = start;
      cfg_go = 1'b0;
      if (!reset) begin
         if (start && word_taken) go = 1'b0;
         word_taken = 1'b0;
         if (!go) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_queue.size() != 0) begin
               head = word_queue[0];
               if (!head.is_cfg) begin
                  go          = 1'b1;
                  req_cmd     <= head.cmd;
                  req_key     <= head.key;
                  req_data_in <= head.data;
                  void'(word_queue.pop_front());
                  gap_left = $urandom_range(0, 12);
               end else if (pending_rsp.size() == 0 && !busy) begin
                  cfg_go    = 1'b1;
                  csr_wdata <= head.limit;
                  void'(word_queue.pop_front());
                  gap_left = $urandom_range(0, 12);
               end
            end
         end
      end
      start  <= go;
      csr_we <= cfg_go;
   end

   // monitor: sample at the rising edge, predict accepted words, check results
   always @(posedge clock) begin
      logic          hit;
      data_type      dout;
      cache_rsp_type want;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_cnt,
                  pending_rsp.size());
         $display("tb: failure");
         $finish;
      end else if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
         end
         slot_fill  = 0;
         slot_limit = CFG_RESET;
      end else begin
         if (rsp_valid) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected result found=%0b data=%h", $time, rsp_found,
                        rsp_data_out);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_found !== want.found) begin
                  errors++;
                  $display("%0t: found expected %0b actual %0b", $time, want.found, rsp_found);
               end
               if (rsp_data_out !== want.data) begin
                  errors++;
                  $display("%0t: data_out expected %h actual %h", $time, want.data,
                           rsp_data_out);
               end
            end
         end
         if (csr_we) begin
            slot_limit = csr_wdata;
            n_limit++;
         end
         if (start && !busy) begin
            cache_access(req_cmd, req_key, req_data_in, hit, dout);
            want.found = hit;
            want.data  = dout;
            pending_rsp.push_back(want);
            word_taken = 1'b1;
            if (req_cmd == CMD_LOOKUP) n_lookup++;
            else n_store++;
            if (hit) n_hit++;
         end
      end
   end

   initial begin
      int       limits[10];
      key_type  pool[24];
      int       pool_n;
      int       cap;
      key_type  k;
      limits = '{31, 16, 1, 4, 17, 8, 0, 2, 16, 12};

      // directed: extremes, replace, ignored data on lookup
      add_access(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      add_access(CMD_STORE, 32'h8000_0000, 32'h7FFF_FFFF);
      add_access(CMD_STORE, 32'h7FFF_FFFF, 32'h8000_0000);
      add_access(CMD_STORE, 32'hFFFF_FFFF, 32'h0000_0000);
      add_access(CMD_STORE, 32'h0000_0000, 32'hFFFF_FFFF);
      add_access(CMD_STORE, 32'h5555_5555, 32'hAAAA_AAAA);
      add_access(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      add_access(CMD_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_access(CMD_LOOKUP, 32'h0000_0000, 32'h1234_5678);
      add_access(CMD_STORE, 32'h7FFF_FFFF, 32'h0000_1234);
      add_access(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
      add_access(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);
      // shrink below occupancy: new keys overwrite the least recent
      add_limit(5'd2);
      add_access(CMD_STORE, 32'h0000_0007, 32'h0000_0070);
      add_access(CMD_STORE, 32'h0000_0008, 32'h0000_0080);
      add_access(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      add_access(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      add_access(CMD_LOOKUP, 32'h0000_0007, 32'h0000_0000);
      add_access(CMD_STORE, 32'h0000_0009, 32'h0000_0090);
      // zero capacity acts as one
      add_limit(5'd0);
      add_access(CMD_STORE, 32'h0000_000A, 32'h0000_00A0);
      add_access(CMD_LOOKUP, 32'h0000_000A, 32'h0000_0000);
      add_access(CMD_LOOKUP, 32'h0000_0009, 32'h0000_0000);
      add_access(CMD_STORE, 32'h0000_000B, 32'h0000_00B0);
      add_access(CMD_LOOKUP, 32'h0000_000A, 32'h0000_0000);

      // random phases: a small key pool per phase keeps hits and evictions frequent
      foreach (limits[p]) begin
         add_limit(limits[p][CFG_W-1:0]);
         cap = limits[p];
         if (cap == 0) cap = 1;
         if (cap > SLOTS) cap = SLOTS;
         pool_n = cap + $urandom_range(1, 6);
         if (pool_n > 24) pool_n = 24;
         for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 9))
               0:       pool[i] = 32'h8000_0000;
               1:       pool[i] = 32'h7FFF_FFFF;
               2:       pool[i] = 32'hFFFF_FFFF;
               3:       pool[i] = 32'h0000_0000;
               default: pool[i] = $urandom;
            endcase
         end
         for (int n = 0; n < 130; n++) begin
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = pool[$urandom_range(0, pool_n - 1)];
            add_access($urandom_range(0, 1) ? CMD_STORE : CMD_LOOKUP, k, $urandom);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (word_queue.size() != 0 || start || pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d lookups and %0d stores, %0d hits, %0d evictions", n_lookup,
               n_store, n_hit, n_evict);
      $display("%0d results checked over %0d capacity settings, %0d mismatches", n_rsp,
               n_limit, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
